// File: sv/cgbd_pkg.sv
// ----------------------------------------------------------------------------
// cgbd_pkg: shared constants for the column gap branch detector
// Field widths, reset values and register indexes used by the interfaces
// and the core.
// ----------------------------------------------------------------------------
package cgbd_pkg;

  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_WIDTH  = 1024;

  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned HEIGHT_W   = 11;
  localparam int unsigned FIELD_W    = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [GRAY_W-1:0]   THRESHOLD_RESET = 8'd127;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 1'd1;

endpackage

// File: sv/cgbd_pixel_if.sv
// ----------------------------------------------------------------------------
// cgbd_pixel_if: pixel stream channel
// One grayscale pixel per word, column-major, with a frame start flag.
// ----------------------------------------------------------------------------
interface cgbd_pixel_if;
  import cgbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_level;
  logic              frame_start;

  modport source (output valid, output gray_level, output frame_start, input ready);
  modport sink   (input valid, input gray_level, input frame_start, output ready);
endinterface

// File: sv/cgbd_branch_if.sv
// ----------------------------------------------------------------------------
// cgbd_branch_if: branch report channel
// One word per detected branch point, giving its column and row.
// ----------------------------------------------------------------------------
interface cgbd_branch_if;
  import cgbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] branch_x;
  logic [FIELD_W-1:0] branch_y;

  modport source (output valid, output branch_x, output branch_y, input ready);
  modport sink   (input valid, input branch_x, input branch_y, output ready);
endinterface

// File: sv/cgbd_cfg_if.sv
// ----------------------------------------------------------------------------
// cgbd_cfg_if: configuration write channel
// Carries a register index and the data to write into that register.
// ----------------------------------------------------------------------------
interface cgbd_cfg_if;
  import cgbd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/column_gap_branch_detector_core.sv
// ----------------------------------------------------------------------------
// column_gap_branch_detector_core: branch detector on a column-major stream
// Binarizes pixels, follows black runs down each column and reports a run
// that lies wholly beside white pixels of the previous column.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_i carries one pixel per word in column-major order; frame_start on
//   a word restarts row, column and run state before that pixel is handled.
//   branch_o carries one word per branch found: the previous column and the
//   first row of the closed black run. Most pixels produce no word.
//   cfg_i writes white_threshold (index 0) and image_height (index 1); it is
//   always ready and must only be used while the block is idle.
// Timing:
//   One pixel is accepted per clock while branch_o does not stall. When a
//   pixel is accepted, its column bit is read from the bit memory into a
//   register beside the stage 1 payload; when stage 1 fires, the run logic
//   and the write back happen and the output register is loaded.
//   One read and one write of the bit memory per clock, with the write
//   forwarded on a same-row hit, sustain one pixel per cycle without stalls.
// Reset and stalls:
//   Reset clears counters, run state and the output register; the bit memory
//   is not cleared and is written in the first column. When branch_o stalls,
//   the output register and one pixel in flight hold, and pixel_i drops
//   ready until the output word is taken.
// ----------------------------------------------------------------------------
module column_gap_branch_detector_core #(
  parameter int unsigned MaxHeight = cgbd_pkg::MAX_HEIGHT,
  parameter int unsigned MaxWidth  = cgbd_pkg::MAX_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cgbd_pixel_if.sink   pixel_i,
  cgbd_cfg_if.sink     cfg_i,
  cgbd_branch_if.source branch_o
);
  import cgbd_pkg::*;

  localparam int unsigned RW  = $clog2(MaxHeight);
  localparam int unsigned CW  = $clog2(MaxWidth);
  localparam int unsigned HCW = (RW + 1 > HEIGHT_W) ? RW + 1 : HEIGHT_W;
  localparam int unsigned XW  = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int unsigned YW  = (RW > FIELD_W) ? RW : FIELD_W;

  localparam logic [HCW-1:0] HeightMax  = HCW'(MaxHeight);
  localparam logic [HCW-1:0] HeightMin  = HCW'(2);
  localparam logic [RW-1:0]  RowLast    = RW'(MaxHeight - 1);
  localparam logic [CW-1:0]  ColLast    = CW'(MaxWidth - 1);

  // Configuration registers.
  logic [GRAY_W-1:0]   threshold_q;
  logic [HEIGHT_W-1:0] height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      height_q    <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WHITE_THRESHOLD: threshold_q <= cfg_i.data[GRAY_W-1:0];
        REG_IMAGE_HEIGHT:    height_q    <= cfg_i.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the two stages and the output register.
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_fire;
  logic accept;

  assign s1_fire       = s1_valid_q && (!out_valid_q || branch_o.ready);
  assign pixel_i.ready = !s1_valid_q || s1_fire;
  assign accept        = pixel_i.valid && pixel_i.ready;

  // Stage 0: row and column counters, memory read address.
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row0;
  logic [CW-1:0]  col0;
  logic [HCW-1:0] height_ext;
  logic [HCW-1:0] eff_height;
  logic           last0;
  logic           white0;

  always_comb begin
    height_ext = HCW'(height_q);
    if (height_ext < HeightMin) begin
      eff_height = HeightMin;
    end else if (height_ext > HeightMax) begin
      eff_height = HeightMax;
    end else begin
      eff_height = height_ext;
    end

    row0 = pixel_i.frame_start ? '0 : row_q;
    col0 = pixel_i.frame_start ? '0 : col_q;
    if (row0 > RowLast) begin
      row0 = RowLast;
    end
    last0  = HCW'(row0) >= (eff_height - HCW'(1));
    white0 = pixel_i.gray_level > threshold_q;

    if (last0) begin
      row_d = '0;
      col_d = (col0 < ColLast) ? col0 + CW'(1) : col0;
    end else begin
      row_d = row0 + RW'(1);
      col_d = col0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Stage 1 payload.
  logic          s1_white_q;
  logic          s1_last_q;
  logic          s1_start_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_white_q <= white0;
      s1_last_q  <= last0;
      s1_start_q <= pixel_i.frame_start;
      s1_row_q   <= row0;
      s1_col_q   <= col0;
    end
  end

  // Previous column bit memory: read at accept, written when stage 1 fires.
  // A write to the address being read in the same cycle is forwarded.
  logic mem_q [MaxHeight];
  logic rdata_q;
  logic fwd_q;
  logic fwd_bit_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_q[s1_row_q] <= s1_white_q;
    end
    if (accept) begin
      rdata_q   <= mem_q[row0];
      fwd_q     <= s1_fire && (s1_row_q == row0);
      fwd_bit_q <= s1_white_q;
    end
  end

  // Stage 1: run tracking.
  logic          in_run_q, in_run_d;
  logic [RW-1:0] start_row_q, start_row_d;
  logic          beside_q, beside_d;
  logic          prev_white;
  logic          close_run;
  logic          hit;

  always_comb begin
    prev_white  = fwd_q ? fwd_bit_q : rdata_q;
    in_run_d    = s1_start_q ? 1'b0 : in_run_q;
    start_row_d = s1_start_q ? '0 : start_row_q;
    beside_d    = s1_start_q ? 1'b1 : beside_q;
    close_run   = 1'b0;

    if (!s1_white_q) begin
      if (!in_run_d) begin
        in_run_d    = 1'b1;
        start_row_d = s1_row_q;
        beside_d    = prev_white;
      end else begin
        beside_d = beside_d && prev_white;
      end
      close_run = s1_last_q;
    end else if (in_run_d) begin
      close_run = 1'b1;
    end

    hit = close_run && beside_d && (s1_col_q != '0);
    if (close_run || s1_last_q) begin
      in_run_d = 1'b0;
      beside_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      start_row_q <= '0;
      beside_q    <= 1'b1;
    end else if (s1_fire) begin
      in_run_q    <= in_run_d;
      start_row_q <= start_row_d;
      beside_q    <= beside_d;
    end
  end

  // Output register.
  logic [XW-1:0]      bx_full;
  logic [YW-1:0]      by_full;
  logic [FIELD_W-1:0] branch_x_q;
  logic [FIELD_W-1:0] branch_y_q;

  assign bx_full = XW'(s1_col_q) - XW'(1);
  assign by_full = YW'(start_row_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= hit;
    end else if (branch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && hit) begin
      branch_x_q <= bx_full[FIELD_W-1:0];
      branch_y_q <= by_full[FIELD_W-1:0];
    end
  end

  assign branch_o.valid    = out_valid_q;
  assign branch_o.branch_x = branch_x_q;
  assign branch_o.branch_y = branch_y_q;

endmodule
